[design/pamd_pkg.sv]
// shared types and constants for the privileged address map decoder
package pamd_pkg;

  // transaction opcodes
  localparam logic [2:0] OP_DECODE     = 3'd0;
  localparam logic [2:0] OP_ADD_REGION = 3'd1;
  localparam logic [2:0] OP_REM_REGION = 3'd2;
  localparam logic [2:0] OP_ADD_REG    = 3'd3;
  localparam logic [2:0] OP_REM_REG    = 3'd4;

  // result status codes
  localparam logic [3:0] ST_REG_HIT    = 4'd0;
  localparam logic [3:0] ST_REGION_HIT = 4'd1;
  localparam logic [3:0] ST_NO_MATCH   = 4'd2;
  localparam logic [3:0] ST_OVERLAP    = 4'd3;
  localparam logic [3:0] ST_MISFIT     = 4'd4;
  localparam logic [3:0] ST_DUPLICATE  = 4'd5;
  localparam logic [3:0] ST_NOT_FOUND  = 4'd6;
  localparam logic [3:0] ST_DONE       = 4'd7;
  localparam logic [3:0] ST_FULL       = 4'd8;

  // privilege and table codes
  localparam logic [1:0] LVL_SYS  = 2'd0;
  localparam logic [1:0] LVL_USR  = 2'd1;
  localparam logic [1:0] LVL_BOTH = 2'd2;

  // packed widths of the stream payloads
  localparam int IN_BITS  = 3 + 16 + 16 + 17 + 2 + 16;
  localparam int IN_BYTES = (IN_BITS + 7) / 8;
  localparam int OUT_BITS = 4 + 4 + 16 + 2 + 5 + 16;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  // classified command from the front end
  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] address;
    logic [15:0] range_end;
    logic [16:0] resource_size;
    logic [1:0]  owner;
    logic [15:0] target_id;
  } cmd_t;

  // result transaction
  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  region_index;
    logic [15:0] local_address;
    logic [1:0]  register_map;
    logic [4:0]  register_slot;
    logic [15:0] assigned_id;
  } res_t;

endpackage

[design/pamd_front.sv]
// front end: accepts input transactions, drops unused opcodes, feeds command queue
module pamd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pamd_pkg::cmd_t      in_cmd,
  output logic                q_valid,
  input  logic                q_ready,
  output pamd_pkg::cmd_t      q_cmd
);
  import pamd_pkg::*;

  cmd_t        slot [2];
  logic [1:0]  count;
  logic        wr_ptr;
  logic        rd_ptr;
  logic        push;
  logic        pop;
  logic        known;

  // opcodes five to seven carry no result and are dropped here
  assign known    = (in_cmd.opcode <= OP_REM_REG);
  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && known;
  assign pop      = q_valid && q_ready;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  // two entry command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("bad queue count");
`endif

endmodule

[design/pamd_back.sv]
// back end: region and register tables, executes one command per cycle unless a held result stalls it
module pamd_back #(
  parameter int REGIONS   = 16,
  parameter int REG_SLOTS = 32,
  parameter int ADDR_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      current_level,
  input  logic            q_valid,
  output logic            q_ready,
  input  pamd_pkg::cmd_t  q_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output pamd_pkg::res_t  out_res
);
  import pamd_pkg::*;

  localparam int RIW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int RSW = (REG_SLOTS > 1) ? $clog2(REG_SLOTS) : 1;
  localparam logic [15:0] AMASK = 16'((17'd1 << ADDR_BITS) - 17'd1);

  // region tables, index 0 system, 1 user
  logic [15:0]        rbase [2][REGIONS];
  logic [15:0]        rlast [2][REGIONS];
  logic [15:0]        rid   [2][REGIONS];
  logic [REGIONS-1:0] rval  [2];
  // register tables, 0 system, 1 user, 2 both
  logic [15:0]          rkey [3][REG_SLOTS];
  logic [REG_SLOTS-1:0] kval [3];
  logic [15:0]          next_id;

  logic [15:0] addr, rend;
  logic        fire;
  logic        lt, ot;
  logic [1:0]  oreg;
  logic [REG_SLOTS-1:0] khit [3];
  logic [REGIONS-1:0]   dhit, ovl, idm;
  logic [REGIONS-1:0]   pwin;
  logic [REGIONS-1:0]   rfree;
  logic [REG_SLOTS-1:0] kfree;
  logic [RIW-1:0] dsel, fsel, psel;
  logic [RSW-1:0] ksel_both, ksel_lvl, ksel_own, kfsel;
  logic            dfound, ffound, pfound, kffound;
  logic [4:0]      rank;
  logic [16:0]     span;
  res_t            res;

  assign addr = q_cmd.address & AMASK;
  assign rend = q_cmd.range_end & AMASK;
  assign lt   = (current_level != LVL_SYS);
  assign ot   = (q_cmd.owner != LVL_SYS);
  assign oreg = (q_cmd.owner >= LVL_BOTH) ? LVL_BOTH : q_cmd.owner;
  assign q_ready = !out_valid || out_ready;
  assign fire = q_valid && q_ready;
  assign span = {1'b0, rend} - {1'b0, addr} + 17'd1;

  // parallel compares over all entries
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      for (int s = 0; s < REG_SLOTS; s++) begin
        khit[t][s] = kval[t][s] && (rkey[t][s] == addr);
      end
    end
    for (int i = 0; i < REGIONS; i++) begin
      dhit[i] = rval[lt][i] && addr >= rbase[lt][i] && addr <= rlast[lt][i];
      ovl[i]  = rval[ot][i] && addr <= rlast[ot][i] && rbase[ot][i] <= rend;
      idm[i]  = rval[ot][i] && rid[ot][i] == q_cmd.target_id;
    end
    // id match with highest base, earliest on ties, by pairwise compares
    for (int i = 0; i < REGIONS; i++) begin
      pwin[i] = idm[i];
      for (int j = 0; j < REGIONS; j++) begin
        if (idm[j] && (rbase[ot][j] > rbase[ot][i] ||
                       (j < i && rbase[ot][j] == rbase[ot][i]))) begin
          pwin[i] = 1'b0;
        end
      end
    end
    rfree = ~rval[ot];
    kfree = ~kval[oreg];
  end

  // lowest set index searches
  always_comb begin
    ksel_both = '0; ksel_lvl = '0; ksel_own = '0; kfsel = '0; kffound = 1'b0;
    for (int s = REG_SLOTS - 1; s >= 0; s--) begin
      if (khit[2][s]) ksel_both = RSW'(s);
      if (khit[lt][s]) ksel_lvl = RSW'(s);
      if (khit[oreg][s]) ksel_own = RSW'(s);
      if (kfree[s]) begin
        kfsel = RSW'(s);
        kffound = 1'b1;
      end
    end
    dsel = '0; dfound = 1'b0; fsel = '0; ffound = 1'b0;
    psel = '0; pfound = 1'b0;
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (dhit[i]) begin
        dsel = RIW'(i);
        dfound = 1'b1;
      end
      if (rfree[i]) begin
        fsel = RIW'(i);
        ffound = 1'b1;
      end
      if (pwin[i]) begin
        psel = RIW'(i);
        pfound = 1'b1;
      end
    end
    rank = '0;
    for (int j = 0; j < REGIONS; j++) begin
      if (rval[lt][j] && rbase[lt][j] > rbase[lt][dsel]) rank = rank + 5'd1;
    end
  end

  // result selection
  always_comb begin
    res = '0;
    unique case (q_cmd.opcode)
      OP_DECODE: begin
        if (|khit[2]) begin
          res.status = ST_REG_HIT;
          res.register_map = LVL_BOTH;
          res.register_slot = 5'(ksel_both);
        end else if (|khit[lt]) begin
          res.status = ST_REG_HIT;
          res.register_map = lt ? LVL_USR : LVL_SYS;
          res.register_slot = 5'(ksel_lvl);
        end else if (dfound) begin
          res.status = ST_REGION_HIT;
          res.region_index = rank[3:0];
          res.local_address = addr - rbase[lt][dsel];
        end else begin
          res.status = ST_NO_MATCH;
        end
      end
      OP_ADD_REGION: begin
        if (|ovl) res.status = ST_OVERLAP;
        else if (rend < addr || span != q_cmd.resource_size) res.status = ST_MISFIT;
        else if (!ffound) res.status = ST_FULL;
        else begin
          res.status = ST_DONE;
          res.assigned_id = next_id;
        end
      end
      OP_REM_REGION: res.status = pfound ? ST_DONE : ST_NOT_FOUND;
      OP_ADD_REG: begin
        if (|khit[oreg] || (oreg == LVL_BOTH && (|khit[0] || |khit[1])))
          res.status = ST_DUPLICATE;
        else if (!kffound) res.status = ST_FULL;
        else res.status = ST_DONE;
      end
      OP_REM_REG: res.status = (|khit[oreg]) ? ST_DONE : ST_NOT_FOUND;
      default: res.status = ST_NO_MATCH;
    endcase
  end

  // table updates and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rval[0] <= '0;
      rval[1] <= '0;
      for (int t = 0; t < 3; t++) kval[t] <= '0;
      next_id <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        if (q_cmd.opcode == OP_ADD_REGION && res.status == ST_DONE) begin
          rval[ot][fsel] <= 1'b1;
          next_id <= next_id + 16'd1;
        end
        if (q_cmd.opcode == OP_REM_REGION && pfound) rval[ot][psel] <= 1'b0;
        if (q_cmd.opcode == OP_ADD_REG && res.status == ST_DONE) kval[oreg][kfsel] <= 1'b1;
        if (q_cmd.opcode == OP_REM_REG && res.status == ST_DONE)
          kval[oreg][ksel_own] <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
      if (q_cmd.opcode == OP_ADD_REGION && res.status == ST_DONE) begin
        rbase[ot][fsel] <= addr;
        rlast[ot][fsel] <= rend;
        rid[ot][fsel]   <= next_id;
      end
      if (q_cmd.opcode == OP_ADD_REG && res.status == ST_DONE) rkey[oreg][kfsel] <= addr;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res)) else $error("result lost");
  a_id_step: assert property (@(posedge clk) disable iff (rst)
    next_id != $past(next_id) |-> $past(fire && q_cmd.opcode == OP_ADD_REGION))
    else $error("id moved without add");
  a_both_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(khit[2])) else $error("duplicate key in shared table");
`endif

endmodule

[design/privileged_address_map_decoder.sv]
// top level: privileged address map decoder with stream ports
//
// Input transactions on s_axis carry an opcode plus address fields; each of
// opcodes 0..4 yields exactly one result transaction on m_axis, opcodes 5..7
// are consumed silently. A front end buffers commands in a two entry queue;
// a back end keeps the region and register tables and executes one command
// per cycle unless a held result stalls it, with all table compares done in parallel.
// From input acceptance a command passes the queue, then the result register,
// before its result is valid. Throughput: one transaction per cycle, limited
// by the single result register when the receiver stalls.
// Stall: when m_axis_tready is low the result holds, the back end stops,
// the queue fills and s_axis_tready drops after two buffered commands.
// Reset (rst, synchronous): all tables empty, id counter zero, level system.
// cfg_we writes current_level from cfg_wdata; the user must write it only while idle, the block does not enforce it.
module privileged_address_map_decoder #(
  parameter int REGIONS   = 16,
  parameter int REG_SLOTS = 32,
  parameter int ADDR_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  // opcode[2:0], address[18:3], range_end[34:19], resource_size[51:35],
  // owner[53:52], target_id[69:54], zero fill
  input  logic [pamd_pkg::IN_BYTES*8-1:0]  s_axis_tdata,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  // status[3:0], region_index[7:4], local_address[23:8], register_map[25:24],
  // register_slot[30:26], assigned_id[46:31], zero fill
  output logic [pamd_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);
  import pamd_pkg::*;

  logic [1:0] current_level;
  cmd_t       in_cmd, q_cmd;
  logic       q_valid, q_ready;
  res_t       res;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= LVL_SYS;
    end else if (cfg_we) begin
      current_level <= cfg_wdata;
    end
  end

  // unpack input fields
  assign in_cmd.opcode        = s_axis_tdata[2:0];
  assign in_cmd.address       = s_axis_tdata[18:3];
  assign in_cmd.range_end     = s_axis_tdata[34:19];
  assign in_cmd.resource_size = s_axis_tdata[51:35];
  assign in_cmd.owner         = s_axis_tdata[53:52];
  assign in_cmd.target_id     = s_axis_tdata[69:54];

  pamd_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  pamd_back #(.REGIONS(REGIONS), .REG_SLOTS(REG_SLOTS), .ADDR_BITS(ADDR_BITS)) u_back (
    .clk(clk), .rst(rst), .current_level(current_level),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

  // pack result fields
  assign m_axis_tdata = {(OUT_BYTES*8-OUT_BITS)'(0), res.assigned_id, res.register_slot,
                         res.register_map, res.local_address, res.region_index,
                         res.status};

endmodule
